>>> hw/rtl/rau_pkg.sv
package rau_pkg;

  localparam int IO_WIDTH  = 32;
  localparam int DEN_WIDTH = 31;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_NORM = 3'd4;
  localparam logic [2:0] OP_EQ   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_LOAD, ACT_SEL, ACT_GCD_INIT, ACT_GCD_STEP, ACT_DIV_N, ACT_DIV_D,
    ACT_DIV_STEP, ACT_STORE, ACT_MUL_P, ACT_MUL_Q, ACT_MUL_D, ACT_COMBINE, ACT_OUT
  } act_t;

  typedef enum logic [1:0] {TGT_A, TGT_B, TGT_R} tgt_t;

  typedef enum logic [1:0] {FIN_NOP, FIN_ZERO, FIN_EQ, FIN_OK} fin_t;

  typedef struct packed {
    act_t act;
    tgt_t tgt;
    fin_t fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       rd_zero;
    logic       gcd_done;
    logic       div_done;
  } stat_t;

endpackage

>>> hw/rtl/rau_datapath.sv
module rau_datapath #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                            clk,
  input  rau_pkg::cmd_t                   cmd,
  output rau_pkg::stat_t                  stat,
  input  logic [2:0]                      in_operation,
  input  logic [rau_pkg::IO_WIDTH-1:0]    in_a_num,
  input  logic [rau_pkg::IO_WIDTH-1:0]    in_a_den,
  input  logic [rau_pkg::IO_WIDTH-1:0]    in_b_num,
  input  logic [rau_pkg::IO_WIDTH-1:0]    in_b_den,
  output logic [rau_pkg::IO_WIDTH-1:0]    out_res_num,
  output logic [rau_pkg::DEN_WIDTH-1:0]   out_res_den,
  output logic                            out_is_equal,
  output logic [1:0]                      out_status
);

  localparam int W  = WORD_WIDTH;
  localparam int DW = 2 * WORD_WIDTH;
  localparam int KW = $clog2(DW);
  localparam int CW = $clog2(DW + 1);
  localparam logic [DW-1:0] LIM = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  // sign and magnitude of the low word bits
  function automatic logic [W:0] take(input logic [rau_pkg::IO_WIDTH-1:0] v);
    logic [W-1:0] w;
    w = v[W-1:0];
    take = {w[W-1], (w[W-1] ? (~w + 1'b1) : w)};
  endfunction

  logic [2:0]    op_r;
  logic          an_neg_r, ad_neg_r, bn_neg_r, bd_neg_r;
  logic [W-1:0]  an_mag_r, ad_mag_r, bn_mag_r, bd_mag_r;
  logic          rn_neg_r, rd_neg_r;
  logic [DW-1:0] rn_r, rd_r;
  logic [DW-1:0] gx_r, gy_r;
  logic [KW-1:0] gk_r;
  logic [DW-1:0] dq_r, rem_r, dv_r, qn_r;
  logic [CW-1:0] cnt_r;
  logic          fa_neg_r, fb_neg_r;
  logic [W-1:0]  fa_mag_r, fa_den_r, fb_mag_r, fb_den_r;
  logic [DW-1:0] p_r, q_r, d_r;
  logic [rau_pkg::IO_WIDTH-1:0]  res_num_r;
  logic [rau_pkg::DEN_WIDTH-1:0] res_den_r;
  logic          is_equal_r;
  logic [1:0]    status_r;

  logic [W:0]    ta_n, ta_d, tb_n, tb_d;
  logic          red_neg;
  logic [DW-1:0] g_val;
  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;
  logic [W-1:0]  mul_a, mul_b;
  logic [DW-1:0] prod;
  logic          q_neg, sum_neg;
  logic [DW-1:0] sum_mag;
  logic          over;
  logic [rau_pkg::IO_WIDTH-1:0] mag32;

  assign ta_n = take(in_a_num);
  assign ta_d = take(in_a_den);
  assign tb_n = take(in_b_num);
  assign tb_d = take(in_b_den);

  assign red_neg   = (qn_r != '0) && (rn_neg_r != rd_neg_r);
  assign g_val     = (gx_r | gy_r) << gk_r;
  assign trial     = {rem_r, dq_r[DW-1]};
  assign trial_sub = trial - {1'b0, dv_r};

  always_comb begin
    mul_a = fa_mag_r;
    mul_b = fb_den_r;
    case (cmd.act)
      rau_pkg::ACT_MUL_P: begin
        mul_a = fa_mag_r;
        mul_b = (op_r == rau_pkg::OP_MUL) ? fb_mag_r : fb_den_r;
      end
      rau_pkg::ACT_MUL_Q: begin
        mul_a = fb_mag_r;
        mul_b = fa_den_r;
      end
      rau_pkg::ACT_MUL_D: begin
        mul_a = fa_den_r;
        mul_b = fb_den_r;
      end
      default: ;
    endcase
  end
  assign prod = DW'(mul_a) * DW'(mul_b);

  always_comb begin
    q_neg = (op_r == rau_pkg::OP_SUB) ? ~fb_neg_r : fb_neg_r;
    if (fa_neg_r == q_neg) begin
      sum_mag = p_r + q_r;
      sum_neg = fa_neg_r;
    end else if (p_r >= q_r) begin
      sum_mag = p_r - q_r;
      sum_neg = fa_neg_r;
    end else begin
      sum_mag = q_r - p_r;
      sum_neg = q_neg;
    end
  end

  assign over  = (dq_r > (LIM - 1'b1)) || (qn_r > (red_neg ? LIM : (LIM - 1'b1)));
  assign mag32 = rau_pkg::IO_WIDTH'(qn_r[W-1:0]);

  always_ff @(posedge clk) begin
    case (cmd.act)
      rau_pkg::ACT_LOAD: begin
        op_r     <= in_operation;
        an_neg_r <= ta_n[W];
        an_mag_r <= ta_n[W-1:0];
        ad_neg_r <= ta_d[W];
        ad_mag_r <= ta_d[W-1:0];
        bn_neg_r <= tb_n[W];
        bn_mag_r <= tb_n[W-1:0];
        bd_neg_r <= tb_d[W];
        bd_mag_r <= tb_d[W-1:0];
      end
      rau_pkg::ACT_SEL: begin
        if (cmd.tgt == rau_pkg::TGT_A) begin
          rn_neg_r <= an_neg_r;
          rn_r     <= DW'(an_mag_r);
          rd_neg_r <= ad_neg_r;
          rd_r     <= DW'(ad_mag_r);
        end else begin
          rn_neg_r <= bn_neg_r;
          rn_r     <= DW'(bn_mag_r);
          rd_neg_r <= bd_neg_r;
          rd_r     <= DW'(bd_mag_r);
        end
      end
      rau_pkg::ACT_GCD_INIT: begin
        gx_r <= rn_r;
        gy_r <= rd_r;
        gk_r <= '0;
      end
      rau_pkg::ACT_GCD_STEP: begin
        if (!gx_r[0] && !gy_r[0]) begin
          gx_r <= gx_r >> 1;
          gy_r <= gy_r >> 1;
          gk_r <= gk_r + 1'b1;
        end else if (!gx_r[0]) begin
          gx_r <= gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_r <= gy_r >> 1;
        end else if (gx_r >= gy_r) begin
          gx_r <= gx_r - gy_r;
        end else begin
          gy_r <= gy_r - gx_r;
        end
      end
      rau_pkg::ACT_DIV_N: begin
        dq_r  <= rn_r;
        rem_r <= '0;
        dv_r  <= g_val;
        cnt_r <= CW'(DW);
      end
      rau_pkg::ACT_DIV_D: begin
        qn_r  <= dq_r;
        dq_r  <= rd_r;
        rem_r <= '0;
        cnt_r <= CW'(DW);
      end
      rau_pkg::ACT_DIV_STEP: begin
        if (!trial_sub[DW]) begin
          rem_r <= trial_sub[DW-1:0];
          dq_r  <= {dq_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= trial[DW-1:0];
          dq_r  <= {dq_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      rau_pkg::ACT_STORE: begin
        if (cmd.tgt == rau_pkg::TGT_A) begin
          fa_neg_r <= red_neg;
          fa_mag_r <= qn_r[W-1:0];
          fa_den_r <= dq_r[W-1:0];
        end else if (cmd.tgt == rau_pkg::TGT_B) begin
          fb_neg_r <= red_neg;
          fb_mag_r <= qn_r[W-1:0];
          fb_den_r <= dq_r[W-1:0];
        end
      end
      rau_pkg::ACT_MUL_P: p_r <= prod;
      rau_pkg::ACT_MUL_Q: q_r <= prod;
      rau_pkg::ACT_MUL_D: d_r <= prod;
      rau_pkg::ACT_COMBINE: begin
        if (op_r == rau_pkg::OP_MUL) begin
          rn_r     <= p_r;
          rn_neg_r <= fa_neg_r ^ fb_neg_r;
          rd_r     <= d_r;
          rd_neg_r <= 1'b0;
        end else if (op_r == rau_pkg::OP_DIV) begin
          rn_r     <= p_r;
          rn_neg_r <= fa_neg_r;
          rd_r     <= q_r;
          rd_neg_r <= fb_neg_r;
        end else begin
          rn_r     <= sum_mag;
          rn_neg_r <= sum_neg;
          rd_r     <= d_r;
          rd_neg_r <= 1'b0;
        end
      end
      rau_pkg::ACT_OUT: begin
        res_num_r  <= '0;
        res_den_r  <= rau_pkg::DEN_WIDTH'(1);
        is_equal_r <= 1'b0;
        status_r   <= rau_pkg::ST_OK;
        case (cmd.fin)
          rau_pkg::FIN_ZERO: status_r <= rau_pkg::ST_ZERO_DEN;
          rau_pkg::FIN_EQ: begin
            is_equal_r <= (fa_neg_r == fb_neg_r) && (fa_mag_r == fb_mag_r)
                          && (fa_den_r == fb_den_r);
          end
          rau_pkg::FIN_OK: begin
            if (over) begin
              status_r <= rau_pkg::ST_OVERFLOW;
            end else begin
              res_num_r <= red_neg ? (~mag32 + 1'b1) : mag32;
              res_den_r <= rau_pkg::DEN_WIDTH'(dq_r[W-2:0]);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign stat.op       = op_r;
  assign stat.rd_zero  = (rd_r == '0);
  assign stat.gcd_done = (gx_r == '0) || (gy_r == '0);
  assign stat.div_done = (cnt_r == '0);

  assign out_res_num  = res_num_r;
  assign out_res_den  = res_den_r;
  assign out_is_equal = is_equal_r;
  assign out_status   = status_r;

endmodule

>>> hw/rtl/rau_ctrl.sv
module rau_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  rau_pkg::stat_t stat,
  output rau_pkg::cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CHECK = 13'b0000000000010,
    S_SEL   = 13'b0000000000100,
    S_CHKZ  = 13'b0000000001000,
    S_GCD   = 13'b0000000010000,
    S_DIVN  = 13'b0000000100000,
    S_DIVD  = 13'b0000001000000,
    S_MULP  = 13'b0000010000000,
    S_MULQ  = 13'b0000100000000,
    S_MULD  = 13'b0001000000000,
    S_COMB  = 13'b0010000000000,
    S_FIN   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t          state_r, state_nxt;
  rau_pkg::tgt_t   tgt_r, tgt_nxt;
  rau_pkg::fin_t   fin_r, fin_nxt;

  always_comb begin
    state_nxt = state_r;
    tgt_nxt   = tgt_r;
    fin_nxt   = fin_r;
    cmd.act   = rau_pkg::ACT_NONE;
    cmd.tgt   = tgt_r;
    cmd.fin   = fin_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.act   = rau_pkg::ACT_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.op > rau_pkg::OP_EQ) begin
          fin_nxt   = rau_pkg::FIN_NOP;
          state_nxt = S_FIN;
        end else begin
          tgt_nxt   = rau_pkg::TGT_A;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        cmd.act   = rau_pkg::ACT_SEL;
        state_nxt = S_CHKZ;
      end
      S_CHKZ: begin
        if (stat.rd_zero) begin
          fin_nxt   = rau_pkg::FIN_ZERO;
          state_nxt = S_FIN;
        end else begin
          cmd.act   = rau_pkg::ACT_GCD_INIT;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.act   = rau_pkg::ACT_DIV_N;
          state_nxt = S_DIVN;
        end else begin
          cmd.act = rau_pkg::ACT_GCD_STEP;
        end
      end
      S_DIVN: begin
        if (stat.div_done) begin
          cmd.act   = rau_pkg::ACT_DIV_D;
          state_nxt = S_DIVD;
        end else begin
          cmd.act = rau_pkg::ACT_DIV_STEP;
        end
      end
      S_DIVD: begin
        if (stat.div_done) begin
          cmd.act = rau_pkg::ACT_STORE;
          case (tgt_r)
            rau_pkg::TGT_A: begin
              if (stat.op == rau_pkg::OP_NORM) begin
                fin_nxt   = rau_pkg::FIN_OK;
                state_nxt = S_FIN;
              end else begin
                tgt_nxt   = rau_pkg::TGT_B;
                state_nxt = S_SEL;
              end
            end
            rau_pkg::TGT_B: begin
              if (stat.op == rau_pkg::OP_EQ) begin
                fin_nxt   = rau_pkg::FIN_EQ;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_MULP;
              end
            end
            default: begin
              fin_nxt   = rau_pkg::FIN_OK;
              state_nxt = S_FIN;
            end
          endcase
        end else begin
          cmd.act = rau_pkg::ACT_DIV_STEP;
        end
      end
      S_MULP: begin
        cmd.act   = rau_pkg::ACT_MUL_P;
        state_nxt = S_MULQ;
      end
      S_MULQ: begin
        cmd.act   = rau_pkg::ACT_MUL_Q;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.act   = rau_pkg::ACT_MUL_D;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.act   = rau_pkg::ACT_COMBINE;
        tgt_nxt   = rau_pkg::TGT_R;
        state_nxt = S_CHKZ;
      end
      S_FIN: begin
        cmd.act   = rau_pkg::ACT_OUT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tgt_r   <= rau_pkg::TGT_A;
      fin_r   <= rau_pkg::FIN_NOP;
    end else begin
      state_r <= state_nxt;
      tgt_r   <= tgt_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

>>> hw/rtl/rational_arithmetic_unit.sv
// Sequence: an unused operation code or a zero denominator in a ends the item early; otherwise
//   one to three reductions, each a binary gcd plus two bit-serial divisions.
// Throughput: one item at a time; the next transfer is taken after the result transfer.
// Reset: rst_n is synchronous, active low; it returns the controller to idle.
module rational_arithmetic_unit #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_operation,
  input  logic [rau_pkg::IO_WIDTH-1:0]  in_a_num,
  input  logic [rau_pkg::IO_WIDTH-1:0]  in_a_den,
  input  logic [rau_pkg::IO_WIDTH-1:0]  in_b_num,
  input  logic [rau_pkg::IO_WIDTH-1:0]  in_b_den,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rau_pkg::IO_WIDTH-1:0]  out_res_num,
  output logic [rau_pkg::DEN_WIDTH-1:0] out_res_den,
  output logic                          out_is_equal,
  output logic [1:0]                    out_status
);

  // Command from the sequencer, status back from the datapath
  rau_pkg::cmd_t  cmd;
  rau_pkg::stat_t stat;

  // Sequencer: walks reduce a, reduce b, cross products, reduce result, as far as the operation needs
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: operand registers, gcd unit, restoring divider, multiplier, result register
  rau_datapath #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (in_operation),
    .in_a_num     (in_a_num),
    .in_a_den     (in_a_den),
    .in_b_num     (in_b_num),
    .in_b_den     (in_b_den),
    .out_res_num  (out_res_num),
    .out_res_den  (out_res_den),
    .out_is_equal (out_is_equal),
    .out_status   (out_status)
  );

endmodule

>>> hw/rtl/rau_checker.sv
module rau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_res_num,
  input logic [30:0] out_res_den,
  input logic        out_is_equal,
  input logic [1:0]  out_status
);

  // busy after taking an item
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 2'd0) |-> (out_res_num == 32'd0) && (out_res_den == 31'd1))
    else $error("error result not 0/1");

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res_den != 31'd0)
    else $error("zero denominator on output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res_num) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
